@@ design/dlt645_frame_decoder_unit_defines.svh @@
// Assertion macros used by the frame parser module.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef DLT645_FRAME_DECODER_UNIT_DEFINES_SVH
`define DLT645_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dlt645_pkg.sv @@
// Shared types and constants of the DL/T 645 frame decoder.
// No dependencies; used by the parser, the output stage and the top level.
package dlt645_pkg;

  localparam logic [7:0] HEAD_MARK   = 8'h68;
  localparam logic [7:0] END_MARK    = 8'h16;
  localparam logic [7:0] DATA_OFFSET = 8'h33;
  localparam logic [7:0] PRE_MARK    = 8'hFE;
  localparam logic [8:0] MIN_FRAME   = 9'd12;
  localparam logic [2:0] PRE_RUN_MAX = 3'd4;
  localparam logic [7:0] MAX_LEN_RST = 8'd255;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_ENDMARK  = 3'd3;
  localparam logic [2:0] ST_LENGTH   = 3'd4;

  localparam int unsigned ADDR_BYTES = 6;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  data_value;
    logic [7:0]  data_index;
    logic [47:0] meter_address;
    logic [7:0]  control_code;
    logic [7:0]  data_length;
    logic [2:0]  status;
  } result_t;

endpackage

@@ design/dlt645_frame_decoder_unit.sv @@
// Top level of the DL/T 645 frame decoder: byte stream in, result stream out.
// Depends on dlt645_pkg, dlt645_parse and dlt645_out_reg.
//
// Usage:
//   Slave side takes one raw byte of a received buffer per transfer, tlast on
//   the final byte of the buffer. Master side gives at most one result per
//   byte: a decoded data byte (tuser low) or, on the final byte, the status
//   result (tuser high, tlast high) with address, control code and length.
//   Bytes outside a frame, header bytes and trailer bytes give no result.
//   A result appears on the master side in the cycle after its byte is
//   taken. Throughput: one byte per cycle, set by the single output register;
//   the next byte is taken while a result waits, as long as the receiver
//   drains it in the same cycle.
//   When the receiver stalls with a result held, tready drops until it is
//   taken; the held result and the parser state stay put.
//   Reset clears the parser to hunting, empties the output register and sets
//   max_data_len to 255. Write cfg_wdata_i via cfg_we_i only while idle.
module dlt645_frame_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // max_data_len write
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_value, [15:8] data_index, [63:16] meter_address,
  // [71:64] control_code, [79:72] data_length, [82:80] status, [87:83] zero
  output logic [87:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser,   // [0] is_status
  output logic        m_axis_tlast    // last
);

  logic [7:0]          max_len_q;
  logic                byte_fire;
  logic                res_valid;
  dlt645_pkg::result_t res;
  dlt645_pkg::result_t out_res;
  logic                out_ready;

  // Length limit register; held across buffers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= dlt645_pkg::MAX_LEN_RST;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = out_ready;
  assign byte_fire     = s_axis_tvalid && out_ready;

  dlt645_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_fire_i (byte_fire),
    .rx_byte_i   (s_axis_tdata),
    .eob_i       (s_axis_tlast),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dlt645_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (byte_fire && res_valid),
    .res_i   (res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // Pack the result, first field in the lowest bits.
  assign m_axis_tdata = {5'd0, out_res.status, out_res.data_length, out_res.control_code,
                         out_res.meter_address, out_res.data_index, out_res.data_value};
  assign m_axis_tuser = out_res.is_status;
  assign m_axis_tlast = out_res.is_status;

endmodule

@@ design/dlt645_parse.sv @@
// Frame parser: holds the frame state and computes at most one result per byte.
// Depends on dlt645_pkg and the assertion macros header.
`include "dlt645_frame_decoder_unit_defines.svh"

module dlt645_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_fire_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                eob_i,
  input  logic [7:0]          max_len_i,
  output logic                res_valid_o,
  output dlt645_pkg::result_t res_o
);

  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_ADDR   = 4'd1;
  localparam logic [3:0] PH_SECOND = 4'd2;
  localparam logic [3:0] PH_CTRL   = 4'd3;
  localparam logic [3:0] PH_LEN    = 4'd4;
  localparam logic [3:0] PH_DATA   = 4'd5;
  localparam logic [3:0] PH_CS     = 4'd6;
  localparam logic [3:0] PH_END    = 4'd7;
  localparam logic [3:0] PH_TRAIL  = 4'd8;
  localparam logic [3:0] PH_FAIL   = 4'd9;

  logic [3:0]  phase_q, phase_d, phase_n;
  logic [2:0]  pre_q, pre_d, pre_n;
  logic [8:0]  pos_q, pos_d, pos_n;
  logic [47:0] addr_q, addr_d, addr_n;
  logic [7:0]  ctrl_q, ctrl_d, ctrl_n;
  logic [7:0]  len_q, len_d, len_n;
  logic [7:0]  sum_q, sum_d, sum_n;
  logic [7:0]  cnt_q, cnt_d, cnt_n;
  logic [2:0]  err_q, err_d, err_n;
  logic [7:0]  sum_add;
  logic [2:0]  addr_k;
  logic        have_data;
  logic [2:0]  final_st;

  assign sum_add = sum_q + rx_byte_i;
  assign addr_k  = pos_q[2:0] - 3'd1;

  // Byte-level transition of the frame state.
  always_comb begin
    phase_n   = phase_q;
    pre_n     = pre_q;
    addr_n    = addr_q;
    ctrl_n    = ctrl_q;
    len_n     = len_q;
    sum_n     = sum_q;
    cnt_n     = cnt_q;
    err_n     = err_q;
    have_data = 1'b0;
    unique case (phase_q)
      PH_HUNT: begin
        if (pre_q >= dlt645_pkg::PRE_RUN_MAX) begin
          if (rx_byte_i == dlt645_pkg::HEAD_MARK) begin
            phase_n = PH_ADDR;
            pre_n   = 3'd0;
            sum_n   = dlt645_pkg::HEAD_MARK;
          end else begin
            err_n   = dlt645_pkg::ST_HEADER;
            phase_n = PH_FAIL;
          end
        end else if (rx_byte_i == dlt645_pkg::HEAD_MARK) begin
          phase_n = PH_ADDR;
          pre_n   = 3'd0;
          sum_n   = dlt645_pkg::HEAD_MARK;
        end else if (rx_byte_i == dlt645_pkg::PRE_MARK) begin
          pre_n = pre_q + 3'd1;
        end else begin
          pre_n = 3'd0;
        end
      end
      PH_ADDR: begin
        for (int i = 0; i < dlt645_pkg::ADDR_BYTES; i++) begin
          if (addr_k == 3'(i)) addr_n[i*8 +: 8] = rx_byte_i;
        end
        sum_n = sum_add;
        if (addr_k >= 3'd5) phase_n = PH_SECOND;
      end
      PH_SECOND: begin
        sum_n = sum_add;
        if (rx_byte_i != dlt645_pkg::HEAD_MARK) begin
          err_n   = dlt645_pkg::ST_HEADER;
          phase_n = PH_FAIL;
        end else begin
          phase_n = PH_CTRL;
        end
      end
      PH_CTRL: begin
        ctrl_n  = rx_byte_i;
        sum_n   = sum_add;
        phase_n = PH_LEN;
      end
      PH_LEN: begin
        len_n = rx_byte_i;
        sum_n = sum_add;
        if (rx_byte_i > max_len_i) begin
          err_n   = dlt645_pkg::ST_HEADER;
          phase_n = PH_FAIL;
        end else begin
          phase_n = (rx_byte_i != 8'd0) ? PH_DATA : PH_CS;
        end
      end
      PH_DATA: begin
        have_data = 1'b1;
        cnt_n     = cnt_q + 8'd1;
        sum_n     = sum_add;
        if (cnt_q + 8'd1 == len_q) phase_n = PH_CS;
      end
      PH_CS: begin
        if (rx_byte_i != sum_q) begin
          err_n   = dlt645_pkg::ST_CHECKSUM;
          phase_n = PH_FAIL;
        end else begin
          phase_n = PH_END;
        end
      end
      PH_END: begin
        if (rx_byte_i != dlt645_pkg::END_MARK) begin
          err_n   = dlt645_pkg::ST_ENDMARK;
          phase_n = PH_FAIL;
        end else begin
          phase_n = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        err_n   = dlt645_pkg::ST_LENGTH;
        phase_n = PH_FAIL;
      end
      default: ;
    endcase
    pos_n = (phase_n != PH_HUNT && pos_q != 9'h1FF) ? pos_q + 9'd1 : pos_q;
  end

  // Status of a buffer that ends on this byte; absent bytes fail their check.
  always_comb begin
    if (phase_n == PH_HUNT || pos_n < dlt645_pkg::MIN_FRAME) begin
      final_st = dlt645_pkg::ST_HEADER;
    end else if (err_n != dlt645_pkg::ST_OK) begin
      final_st = err_n;
    end else begin
      unique case (phase_n)
        PH_DATA, PH_CS: final_st = dlt645_pkg::ST_CHECKSUM;
        PH_END:         final_st = dlt645_pkg::ST_ENDMARK;
        PH_TRAIL:       final_st = dlt645_pkg::ST_OK;
        default:        final_st = dlt645_pkg::ST_HEADER;
      endcase
    end
  end

  always_comb begin
    res_valid_o         = eob_i || have_data;
    res_o.is_status     = eob_i;
    res_o.data_value    = eob_i ? 8'd0 : rx_byte_i - dlt645_pkg::DATA_OFFSET;
    res_o.data_index    = eob_i ? 8'd0 : cnt_q;
    res_o.meter_address = addr_n;
    res_o.control_code  = ctrl_n;
    res_o.data_length   = len_n;
    res_o.status        = eob_i ? final_st : dlt645_pkg::ST_OK;
  end

  // Advance on each transfer; clear back to hunting after the last byte.
  always_comb begin
    phase_d = phase_q;
    pre_d   = pre_q;
    pos_d   = pos_q;
    addr_d  = addr_q;
    ctrl_d  = ctrl_q;
    len_d   = len_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    if (byte_fire_i) begin
      if (eob_i) begin
        phase_d = PH_HUNT;
        pre_d   = 3'd0;
        pos_d   = 9'd0;
        addr_d  = 48'd0;
        ctrl_d  = 8'd0;
        len_d   = 8'd0;
        sum_d   = 8'd0;
        cnt_d   = 8'd0;
        err_d   = dlt645_pkg::ST_OK;
      end else begin
        phase_d = phase_n;
        pre_d   = pre_n;
        pos_d   = pos_n;
        addr_d  = addr_n;
        ctrl_d  = ctrl_n;
        len_d   = len_n;
        sum_d   = sum_n;
        cnt_d   = cnt_n;
        err_d   = err_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pre_q   <= 3'd0;
      pos_q   <= 9'd0;
      addr_q  <= 48'd0;
      ctrl_q  <= 8'd0;
      len_q   <= 8'd0;
      sum_q   <= 8'd0;
      cnt_q   <= 8'd0;
      err_q   <= dlt645_pkg::ST_OK;
    end else begin
      phase_q <= phase_d;
      pre_q   <= pre_d;
      pos_q   <= pos_d;
      addr_q  <= addr_d;
      ctrl_q  <= ctrl_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  `DLT_ASSERT_NOW(a_hunt_pos_zero, phase_q == PH_HUNT, pos_q == 9'd0 && err_q == dlt645_pkg::ST_OK, "position or error left over while hunting")
  `DLT_ASSERT_NOW(a_data_in_range, phase_q == PH_DATA, cnt_q < len_q && len_q != 8'd0, "data count outside the announced length")
  `DLT_ASSERT_NEXT(a_eob_clears, byte_fire_i && eob_i, phase_q == PH_HUNT && pre_q == 3'd0, "state not cleared after the last byte")
  `DLT_ASSERT_NOW(a_pre_bound, phase_q == PH_HUNT, pre_q <= dlt645_pkg::PRE_RUN_MAX, "preamble run beyond four")

endmodule

@@ design/dlt645_out_reg.sv @@
// Output register stage of the frame decoder; parts input and output handshakes.
// Depends on dlt645_pkg for the result type.
module dlt645_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dlt645_pkg::result_t res_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                ready_i,
  output dlt645_pkg::result_t res_o
);

  logic                valid_q, valid_d;
  dlt645_pkg::result_t res_q;

  // Free when empty or being drained in this cycle.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = push_i || (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ tb/dlt645_frame_decoder_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for dlt645_frame_decoder_unit: drives received buffers
// byte by byte and checks every decoded data byte and buffer status on the fly.
// Depends on dlt645_pkg and the decoder RTL only.
module dlt645_frame_decoder_unit_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam int unsigned DRAIN_TICKS  = 10;
  localparam int unsigned PHASE_ITEMS  = 205;
  localparam int unsigned PHASE_COUNT  = 5;

  // Parser phases of the frame decoding model.
  typedef enum logic [3:0] {
    P_HUNT, P_ADDR, P_SECOND, P_CTRL, P_LEN, P_DATA, P_CS, P_END, P_TRAIL, P_FAIL
  } parse_phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
  logic        s_axis_tlast;    // end_of_buffer
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] data_value, [15:8] data_index, [63:16] meter_address,
  // [71:64] control_code, [79:72] data_length, [82:80] status, [87:83] zero
  logic [87:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;    // [0] is_status
  logic        m_axis_tlast;    // last

  dlt645_frame_decoder_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Frame decoding model plus the queue of results still owed by the block.
  class frame_scoreboard;
    logic [7:0]          max_len;
    parse_phase_e        phase;
    logic [2:0]          fe_run;
    logic [8:0]          pos;
    logic [47:0]         addr;
    logic [7:0]          ctrl;
    logic [7:0]          len;
    logic [7:0]          sum;
    logic [7:0]          dcount;
    logic [2:0]          err;
    dlt645_pkg::result_t owed_q[$];
    int                  errors;
    int                  data_results;
    int                  status_hist[8];

    function new();
      max_len      = dlt645_pkg::MAX_LEN_RST;
      errors       = 0;
      data_results = 0;
      foreach (status_hist[i]) status_hist[i] = 0;
      clear();
    endfunction

    function void clear();
      phase  = P_HUNT;
      fe_run = '0;
      pos    = '0;
      addr   = '0;
      ctrl   = '0;
      len    = '0;
      sum    = '0;
      dcount = '0;
      err    = dlt645_pkg::ST_OK;
    endfunction

    function void start_frame();
      phase  = P_ADDR;
      fe_run = '0;
      sum    = dlt645_pkg::HEAD_MARK;
    endfunction

    function void fail(logic [2:0] code);
      err   = code;
      phase = P_FAIL;
    endfunction

    // Status of a buffer that ends in the current phase.
    function logic [2:0] closing_status();
      if (phase == P_HUNT || pos < dlt645_pkg::MIN_FRAME) return dlt645_pkg::ST_HEADER;
      if (err != dlt645_pkg::ST_OK) return err;
      case (phase)
        P_DATA, P_CS: return dlt645_pkg::ST_CHECKSUM;
        P_END:        return dlt645_pkg::ST_ENDMARK;
        P_TRAIL:      return dlt645_pkg::ST_OK;
        default:      return dlt645_pkg::ST_HEADER;
      endcase
    endfunction

    // Advance the model by one accepted byte and queue the result it owes.
    function void note_byte(logic [7:0] b, logic eob);
      dlt645_pkg::result_t r;
      logic       emit;
      logic [7:0] dv;
      logic [7:0] di;
      int         k;
      emit = 1'b0;
      dv   = '0;
      di   = '0;
      case (phase)
        P_HUNT: begin
          if (fe_run >= dlt645_pkg::PRE_RUN_MAX) begin
            if (b == dlt645_pkg::HEAD_MARK) start_frame();
            else fail(dlt645_pkg::ST_HEADER);
          end else if (b == dlt645_pkg::HEAD_MARK) begin
            start_frame();
          end else if (b == dlt645_pkg::PRE_MARK) begin
            fe_run++;
          end else begin
            fe_run = '0;
          end
        end
        P_ADDR: begin
          k = int'((pos - 9'd1) & 9'd7);
          if (k < 6) addr[8*k +: 8] = b;
          sum += b;
          if (k >= 5) phase = P_SECOND;
        end
        P_SECOND: begin
          sum += b;
          if (b != dlt645_pkg::HEAD_MARK) fail(dlt645_pkg::ST_HEADER);
          else phase = P_CTRL;
        end
        P_CTRL: begin
          ctrl  = b;
          sum  += b;
          phase = P_LEN;
        end
        P_LEN: begin
          len  = b;
          sum += b;
          if (b > max_len) fail(dlt645_pkg::ST_HEADER);
          else phase = (b != 8'd0) ? P_DATA : P_CS;
        end
        P_DATA: begin
          emit = 1'b1;
          dv   = b - dlt645_pkg::DATA_OFFSET;
          di   = dcount;
          dcount++;
          sum += b;
          if (dcount == len) phase = P_CS;
        end
        P_CS: begin
          if (b != sum) fail(dlt645_pkg::ST_CHECKSUM);
          else phase = P_END;
        end
        P_END: begin
          if (b != dlt645_pkg::END_MARK) fail(dlt645_pkg::ST_ENDMARK);
          else phase = P_TRAIL;
        end
        P_TRAIL: fail(dlt645_pkg::ST_LENGTH);
        default: ;
      endcase

      if (phase != P_HUNT && pos < 9'd511) pos++;

      r               = '0;
      r.meter_address = addr;
      r.control_code  = ctrl;
      r.data_length   = len;
      if (eob) begin
        // the status result takes the place of any data result
        r.is_status = 1'b1;
        r.status    = closing_status();
        owed_q.push_back(r);
        status_hist[r.status]++;
        clear();
      end else if (emit) begin
        r.data_value = dv;
        r.data_index = di;
        owed_q.push_back(r);
        data_results++;
      end
    endfunction

    function void compare_field(string field, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
      end
    endfunction

    // Compare one result transfer against the oldest owed result.
    function void check_result(logic [87:0] d, logic user, logic lst);
      dlt645_pkg::result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser %0b",
                 $time, d, user);
        return;
      end
      want = owed_q.pop_front();
      compare_field("is_status",     want.is_status,     user);
      compare_field("data_value",    want.data_value,    d[7:0]);
      compare_field("data_index",    want.data_index,    d[15:8]);
      compare_field("meter_address", want.meter_address, d[63:16]);
      compare_field("control_code",  want.control_code,  d[71:64]);
      compare_field("data_length",   want.data_length,   d[79:72]);
      compare_field("status",        want.status,        d[82:80]);
      compare_field("last",          want.is_status,     lst);
      compare_field("tdata padding", '0,                 d[87:83]);
    endfunction
  endclass

  frame_scoreboard sb = new();

  logic [7:0] rx_q[$];     // bytes of the buffer being sent
  bit         no_idle;     // both sides run without gaps for this buffer
  bit         hold_req;    // ask the receiver for one long hold-off
  int         items_sent;
  int         buffers_sent;
  int         cycles;

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.owed_q.size());
      $display("dlt645_frame_decoder_unit_tb: FAIL");
      $finish;
    end
  end

  // Observe both sides in one process: note the input transfer first, so that
  // its expectation is in place before a result of the same edge is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
    end
  end

  // Receiver: draw a stall before each result, and serve one long hold-off on
  // request so that the output register fills and the input side backs up.
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Offer one byte after a random gap; keep tvalid high when no gap follows.
  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    items_sent++;
  endtask

  task automatic send_buffer();
    no_idle = ($urandom_range(0, 4) == 0);
    foreach (rx_q[i]) send_byte(rx_q[i], i == rx_q.size() - 1);
    buffers_sent++;
  endtask

  // Write max_data_len once the block has gone quiet.
  task automatic write_max_len(input logic [7:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.max_len   = v;
  endtask

  // A byte that neither opens a frame, extends a preamble nor ends a frame.
  function automatic logic [7:0] filler_byte();
    logic [7:0] v;
    do v = 8'($urandom);
    while (v == dlt645_pkg::HEAD_MARK || v == dlt645_pkg::PRE_MARK ||
           v == dlt645_pkg::END_MARK);
    return v;
  endfunction

  // Sum of the buffer from the opening 0x68 at index first to its end.
  function automatic logic [7:0] frame_sum(int first);
    logic [7:0] s;
    s = '0;
    for (int i = first; i < rx_q.size(); i++) s += rx_q[i];
    return s;
  endfunction

  // Build one random buffer. The largest share are well-formed frames with random content;
  // the rest are noise, bad preambles, broken headers, bad sums, bad end
  // marks, trailing bytes and buffers cut short.
  function automatic void make_buffer();
    int         kind;
    int         r;
    int         len;
    int         first;
    int         cut;
    logic [7:0] s;
    rx_q.delete();
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) rx_q.push_back(filler_byte());
    if (kind < 6) begin
      // line noise of any value, possibly opening frames by chance
      repeat ($urandom_range(1, 20)) rx_q.push_back(8'($urandom));
      return;
    end
    if (kind < 12) begin
      // full preamble run followed by something other than a start mark
      repeat (4) rx_q.push_back(dlt645_pkg::PRE_MARK);
      rx_q.push_back(filler_byte());
      repeat ($urandom_range(0, 15)) rx_q.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 4)) rx_q.push_back(dlt645_pkg::PRE_MARK);
    first = rx_q.size();
    rx_q.push_back(dlt645_pkg::HEAD_MARK);
    r = $urandom_range(0, 7);
    for (int i = 0; i < dlt645_pkg::ADDR_BYTES; i++)
      rx_q.push_back(r == 0 ? 8'h00 : (r == 1 ? 8'hFF : 8'($urandom)));
    rx_q.push_back(kind < 18 ? filler_byte() : dlt645_pkg::HEAD_MARK);
    rx_q.push_back(8'($urandom));
    // mostly short data fields; now and then a long one or one past the limit
    r = $urandom_range(0, 19);
    if (r == 0)
      len = $urandom_range(0, 255);
    else if (r < 3)
      len = (sb.max_len == 8'hFF) ? 255 : int'(sb.max_len) + 1;
    else
      len = $urandom_range(0, (sb.max_len < 8'd12) ? int'(sb.max_len) : 12);
    rx_q.push_back(8'(len));
    repeat (len) rx_q.push_back(8'($urandom));
    s = frame_sum(first);
    rx_q.push_back(kind < 26 ? s ^ 8'($urandom_range(1, 255)) : s);
    rx_q.push_back(kind < 34 ? filler_byte() : dlt645_pkg::END_MARK);
    if (kind >= 34 && kind < 44) begin
      repeat ($urandom_range(1, 3)) rx_q.push_back(8'($urandom));
    end else if (kind >= 44 && kind < 60) begin
      // drop the tail: the buffer ends somewhere inside the frame
      cut = $urandom_range(first + 1, rx_q.size() - 1);
      while (rx_q.size() > cut) void'(rx_q.pop_back());
    end
  endfunction

  initial begin
    logic [7:0] limits[PHASE_COUNT];
    int         target;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    items_sent     = 0;
    buffers_sent   = 0;
    cycles         = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, at the reset limit: a full-preamble frame with extreme address
    // bytes, a control code of all ones and the data byte that decodes to 0xFF.
    rx_q = {dlt645_pkg::PRE_MARK, dlt645_pkg::PRE_MARK, dlt645_pkg::PRE_MARK,
            dlt645_pkg::PRE_MARK, dlt645_pkg::HEAD_MARK,
            8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
            dlt645_pkg::HEAD_MARK, 8'hFF, 8'h01, 8'h32};
    rx_q.push_back(frame_sum(4));
    rx_q.push_back(dlt645_pkg::END_MARK);
    send_buffer();
    // a one-byte buffer with no frame in it
    rx_q = {8'h00};
    send_buffer();
    // a full preamble run broken by a zero byte
    rx_q = {dlt645_pkg::PRE_MARK, dlt645_pkg::PRE_MARK, dlt645_pkg::PRE_MARK,
            dlt645_pkg::PRE_MARK, 8'h00};
    send_buffer();

    // Random phases, each under its own length limit, extremes included.
    limits = '{8'd0, 8'd7, 8'd255, 8'($urandom_range(1, 254)), 8'd255};
    target = items_sent;
    foreach (limits[p]) begin
      write_max_len(limits[p]);
      if (p == 1) hold_req = 1'b1;
      target += PHASE_ITEMS;
      while (items_sent < target) begin
        make_buffer();
        send_buffer();
      end
    end

    // Drain: wait for every owed result, then a little longer for strays.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);

    $display("run covered %0d buffers, %0d bytes, %0d decoded data bytes, %0d cycles",
             buffers_sent, items_sent, sb.data_results, cycles);
    $display("buffer outcomes: ok %0d, header %0d, checksum %0d, end mark %0d, length %0d",
             sb.status_hist[dlt645_pkg::ST_OK], sb.status_hist[dlt645_pkg::ST_HEADER],
             sb.status_hist[dlt645_pkg::ST_CHECKSUM], sb.status_hist[dlt645_pkg::ST_ENDMARK],
             sb.status_hist[dlt645_pkg::ST_LENGTH]);
    if (sb.errors == 0) begin
      $display("dlt645_frame_decoder_unit_tb: PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("dlt645_frame_decoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
